// ----- hdl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test unit
// Widths of the vertex table, the coordinates and the stream payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  // Table depth and coordinate width
  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;
  localparam int IDX_BITS     = $clog2(MAX_VERTICES);

  // Fixed field widths of the stream items and the count register
  localparam int VIDX_BITS    = 4;
  localparam int CNT_BITS     = 5;
  localparam int CNT_MAX      = (1 << CNT_BITS) - 1;

  // Edge arithmetic: differences need one extra bit, products twice that
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;

  // Stream payload widths, rounded up to whole bytes
  localparam int S_DATA_RAW   = VIDX_BITS + 2 * COORD_BITS;
  localparam int S_DATA_BITS  = ((S_DATA_RAW + 7) / 8) * 8;
  localparam int M_DATA_RAW   = 1 + CNT_BITS;
  localparam int M_DATA_BITS  = ((M_DATA_RAW + 7) / 8) * 8;

  // Register file
  localparam int PADDR_BITS   = 3;
  localparam int PDATA_BITS   = 32;

  // Item kinds carried in s_tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Register index decoded from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic [IDX_BITS-1:0]          vidx_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  // One edge handed to the evaluator, with the query point
  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t px;
    coord_t py;
  } pip_edge_t;

  // Verdict for one edge
  typedef struct packed {
    logic valid;
    logic last;
    logic crossed;
  } pip_hit_t;

  // Query sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_LAST,
    ST_WRAP,
    ST_WAIT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/pip_vertex_mem.sv -----
// ----------------------------------------------------------------------------
// pip_vertex_mem: vertex table
// Synchronous x/y memory, one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_vertex_mem (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire pip_pkg::vidx_t waddr,
  input  wire pip_pkg::coord_t wx,
  input  wire pip_pkg::coord_t wy,
  input  wire logic           re,
  input  wire pip_pkg::vidx_t raddr,
  output pip_pkg::coord_t     rx,
  output pip_pkg::coord_t     ry
);
  import pip_pkg::*;

  coord_t mem_x [MAX_VERTICES];
  coord_t mem_y [MAX_VERTICES];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rx <= mem_x[raddr];
      ry <= mem_y[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pip_edge_eval.sv -----
// ----------------------------------------------------------------------------
// pip_edge_eval: edge crossing test
// Three-stage pipeline: span check and differences, products, compare.
// Crossing when a*ex > ep*d with a >= 0, d > 0 (edge x right of point).
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_eval (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pip_pkg::pip_edge_t edge_in,
  output pip_pkg::pip_hit_t      hit
);
  import pip_pkg::*;

  // stage 1 registers
  logic  s1_valid, s1_last, s1_span;
  diff_t s1_a, s1_d, s1_ex, s1_ep;
  // stage 2 registers
  logic  s2_valid, s2_last, s2_span;
  prod_t s2_lhs, s2_rhs;

  // sign-extended coordinates
  diff_t x1e, y1e, x2e, y2e, pxe, pye;
  logic  up, span;
  diff_t a_c, d_c;

  assign x1e = {edge_in.x1[COORD_BITS-1], edge_in.x1};
  assign y1e = {edge_in.y1[COORD_BITS-1], edge_in.y1};
  assign x2e = {edge_in.x2[COORD_BITS-1], edge_in.x2};
  assign y2e = {edge_in.y2[COORD_BITS-1], edge_in.y2};
  assign pxe = {edge_in.px[COORD_BITS-1], edge_in.px};
  assign pye = {edge_in.py[COORD_BITS-1], edge_in.py};

  // half-open span [min y, max y); horizontal edges never qualify
  always_comb begin
    up   = edge_in.y1 < edge_in.y2;
    if (up) begin
      span = (edge_in.py >= edge_in.y1) && (edge_in.py < edge_in.y2);
      a_c  = pye - y1e;
      d_c  = y2e - y1e;
    end else begin
      span = (edge_in.y2 < edge_in.y1) && (edge_in.py >= edge_in.y2) &&
             (edge_in.py < edge_in.y1);
      a_c  = y1e - pye;
      d_c  = y1e - y2e;
    end
  end

  // stage 1: differences, normalized so that d is never negative
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= edge_in.valid;
    end
    s1_last <= edge_in.last;
    s1_span <= span;
    s1_a    <= a_c;
    s1_d    <= d_c;
    s1_ex   <= x2e - x1e;
    s1_ep   <= pxe - x1e;
  end

  // stage 2: the two cross products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_last <= s1_last;
    s2_span <= s1_span;
    s2_lhs  <= s1_a * s1_ex;
    s2_rhs  <= s1_ep * s1_d;
  end

  // stage 3: exact compare
  always_ff @(posedge clk) begin
    if (rst) begin
      hit.valid <= 1'b0;
    end else begin
      hit.valid <= s2_valid;
    end
    hit.last    <= s2_last;
    hit.crossed <= s2_span && (s2_lhs > s2_rhs);
  end

endmodule

`default_nettype wire

// ----- hdl/point_in_polygon_test_unit.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit: crossing-number point-in-polygon tester
// Vertex writes fill a table; a query walks the stored edges and returns
// the crossing count and its parity.
// ----------------------------------------------------------------------------
// Sequencing: write beats are accepted while idle. A query walks the table
//   through RUN, LAST, WRAP, WAIT and FINISH (straight to FINISH with n = 0),
//   reading one vertex per cycle through the single read port of the vertex
//   table into the 3-stage edge pipeline; the result beat is loaded in FINISH
//   once the output is free. No new beat is accepted until IDLE is reached.
// Reset: rst clears vertex_count, the sequencer and the output beat; the
//   vertex table is not cleared and must be written before use.
`default_nettype none

module point_in_polygon_test_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [3:0] vertex_index, [19:4] point_x, [35:20] point_y, rest zero
  input  wire logic [pip_pkg::S_DATA_BITS-1:0]   s_tdata,
  // [0] func
  input  wire logic                              s_tuser,
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [0] inside_res, [5:1] crossings, rest zero
  output logic [pip_pkg::M_DATA_BITS-1:0]        m_tdata,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pip_pkg::PADDR_BITS-1:0]    paddr,
  input  wire logic [pip_pkg::PDATA_BITS-1:0]    pwdata,
  output logic [pip_pkg::PDATA_BITS-1:0]         prdata,
  output logic                                   pready
);
  import pip_pkg::*;

  state_t state, state_next;

  cnt_t   vertex_count;
  vidx_t  rd_addr;
  vidx_t  n_last;
  coord_t qx, qy;
  coord_t first_x, first_y, prev_x, prev_y;
  coord_t rx, ry;
  logic   rd_vld, rd_first;
  cnt_t   crossings;
  logic   parity;
  cnt_t   out_cnt;
  logic   out_inside;

  logic   s_beat, m_beat, is_query, wr_en, rd_en, wrap_go, load_out, out_free;
  logic   [VIDX_BITS-1:0] in_idx;
  coord_t in_x, in_y;
  int     n_eff;

  pip_edge_t edge_item;
  pip_hit_t  hit;

  // input field unpacking
  assign in_idx   = s_tdata[VIDX_BITS-1:0];
  assign in_x     = s_tdata[VIDX_BITS +: COORD_BITS];
  assign in_y     = s_tdata[VIDX_BITS+COORD_BITS +: COORD_BITS];
  assign s_beat   = s_tvalid && s_tready;
  assign m_beat   = m_tvalid && m_tready;
  assign is_query = (s_tuser == FUNC_QUERY);
  assign out_free = !m_tvalid || m_tready;
  assign wr_en    = s_beat && !is_query && (int'(in_idx) < MAX_VERTICES);

  // vertices in use, clipped to the table depth
  assign n_eff = (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[CNT_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VERTEX_COUNT) begin
      prdata[CNT_BITS-1:0] = vertex_count;
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_beat && is_query) begin
          state_next = (n_eff == 0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (rd_addr == n_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST:  state_next = ST_WRAP;
      ST_WRAP:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (hit.valid && hit.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    wrap_go  = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_RUN:    rd_en    = 1'b1;
      ST_WRAP:   wrap_go  = 1'b1;
      ST_FINISH: load_out = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // query capture and read address walk
  always_ff @(posedge clk) begin
    if (s_beat && is_query) begin
      qx      <= in_x;
      qy      <= in_y;
      n_last  <= IDX_BITS'(n_eff - 1);
      rd_addr <= '0;
    end else if (rd_en) begin
      rd_addr <= rd_addr + 1'b1;
    end
  end

  // read-valid tracking for the registered table read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      rd_first <= rd_en && (rd_addr == '0);
    end
  end

  // vertex table
  pip_vertex_mem u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IDX_BITS'(in_idx)),
    .wx    (in_x),
    .wy    (in_y),
    .re    (rd_en),
    .raddr (rd_addr),
    .rx    (rx),
    .ry    (ry)
  );

  // hold the first and the previous vertex
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev_x <= rx;
      prev_y <= ry;
      if (rd_first) begin
        first_x <= rx;
        first_y <= ry;
      end
    end
  end

  // edge issue: consecutive pairs as they arrive, then the closing edge
  always_comb begin
    edge_item.valid = (rd_vld && !rd_first) || wrap_go;
    edge_item.last  = wrap_go;
    edge_item.x1    = prev_x;
    edge_item.y1    = prev_y;
    edge_item.x2    = wrap_go ? first_x : rx;
    edge_item.y2    = wrap_go ? first_y : ry;
    edge_item.px    = qx;
    edge_item.py    = qy;
  end

  pip_edge_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .edge_in (edge_item),
    .hit     (hit)
  );

  // crossing count (saturating) and parity
  always_ff @(posedge clk) begin
    if (s_beat && is_query) begin
      crossings <= '0;
      parity    <= 1'b0;
    end else if (hit.valid && hit.crossed) begin
      if (crossings != cnt_t'(CNT_MAX)) begin
        crossings <= crossings + 1'b1;
      end
      parity <= !parity;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_beat) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cnt    <= crossings;
      out_inside <= parity;
    end
  end

  always_comb begin
    m_tdata                  = '0;
    m_tdata[0]               = out_inside;
    m_tdata[CNT_BITS:1]      = out_cnt;
  end

  // checks
  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINISH)
    else $error("result beat raised outside the finish state");

  a_last_hit_in_wait: assert property (@(posedge clk) disable iff (rst)
    (hit.valid && hit.last) |-> state == ST_WAIT)
    else $error("closing edge verdict arrived outside the wait state");

  a_edge_in_walk: assert property (@(posedge clk) disable iff (rst)
    edge_item.valid |-> (state == ST_RUN || state == ST_LAST || state == ST_WRAP))
    else $error("edge issued outside a table walk");

  a_parity_match: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_cnt != cnt_t'(CNT_MAX)) |-> out_inside == out_cnt[0])
    else $error("inside flag disagrees with crossing count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> int'(out_cnt) <= MAX_VERTICES)
    else $error("crossing count exceeds edge count");

endmodule

`default_nettype wire
